FILE: hw/rtl/interrupt_storm_generator_core_macros.svh
// ----------------------------------------------------------------------------
// interrupt storm generator assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_STORM_GENERATOR_CORE_MACROS_SVH
`define INTERRUPT_STORM_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, held off during reset
`define ISG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define ISG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/isg_pkg.sv
// ----------------------------------------------------------------------------
// isg_pkg
// types, register offsets and reset values of the interrupt storm generator
// ----------------------------------------------------------------------------
package isg_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned OFF_W   = 5;
    localparam int unsigned ACT_W   = 2;
    localparam int unsigned PULSE_W = 17;
    localparam int unsigned IRQN_W  = 4;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 56;

    // actions
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

    // register offsets
    localparam logic [OFF_W-1:0] OFF_CONTROL   = 5'h00;
    localparam logic [OFF_W-1:0] OFF_IRQ_NUM   = 5'h01;
    localparam logic [OFF_W-1:0] OFF_BURST     = 5'h02;
    localparam logic [OFF_W-1:0] OFF_STATUS    = 5'h03;
    localparam logic [OFF_W-1:0] OFF_PERIOD    = 5'h04;
    localparam logic [OFF_W-1:0] OFF_PULSES_LO = 5'h08;
    localparam logic [OFF_W-1:0] OFF_PULSES_HI = 5'h0c;
    localparam logic [OFF_W-1:0] OFF_FIRES     = 5'h10;
    localparam logic [OFF_W-1:0] OFF_CHANGED   = 5'h14;
    localparam logic [OFF_W-1:0] OFF_TOGGLES   = 5'h18;
    localparam logic [OFF_W-1:0] OFF_ACK       = 5'h1c;

    // control bits
    localparam int unsigned CTRL_ENABLE_BIT = 0;
    localparam int unsigned CTRL_LEVEL_BIT  = 1;

    localparam logic [PULSE_W-1:0] MAX_BURST = 17'd100000;

    // reset values
    localparam logic [1:0]        RST_CONTROL = 2'b01;
    localparam logic [IRQN_W-1:0] RST_IRQ_NUM = 4'd5;
    localparam logic [DATA_W-1:0] RST_BURST   = 32'd128;
    localparam logic [DATA_W-1:0] RST_PERIOD  = 32'd100;

    typedef struct packed {
        logic [DATA_W-1:0] write_data;
        logic [OFF_W-1:0]  offset;
        logic [ACT_W-1:0]  action;
    } item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_count;
        logic               irq_level;
        logic [DATA_W-1:0]  read_data;
    } result_t;

    function automatic logic [DATA_W-1:0] reload_of(input logic [DATA_W-1:0] period);
        reload_of = (period == '0) ? DATA_W'(1) : period;
    endfunction

endpackage

FILE: hw/rtl/isg_in_stage.sv
// ----------------------------------------------------------------------------
// isg_in_stage
// input register that holds one transaction while the engine is stalled
// ----------------------------------------------------------------------------
module isg_in_stage
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [isg_pkg::IN_TDATA_W-1:0]        s_tdata,
    input  logic                                  take,
    output logic                                  item_valid,
    output isg_pkg::item_t                        item
);
    import isg_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_t'(s_tdata[$bits(item_t)-1:0]);
        end
    end

endmodule

FILE: hw/rtl/isg_engine.sv
// ----------------------------------------------------------------------------
// isg_engine
// register file, countdown, counters and result register
// ----------------------------------------------------------------------------
module isg_engine
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [isg_pkg::IRQN_W-1:0]     cfg_wr_data,
    input  logic                           item_valid,
    input  isg_pkg::item_t                 item,
    output logic                           take,
    output logic                           res_valid,
    input  logic                           res_ready,
    output isg_pkg::result_t               res
);
    import isg_pkg::*;

    logic [1:0]         control_reg,  control_next;
    logic [IRQN_W-1:0]  irq_num_reg;
    logic [DATA_W-1:0]  burst_reg,    burst_next;
    logic [DATA_W-1:0]  period_reg,   period_next;
    logic [DATA_W-1:0]  countdown_reg, countdown_next;
    logic               line_reg,     line_next;
    logic [63:0]        pulses_reg,   pulses_next;
    logic [DATA_W-1:0]  fires_reg,    fires_next;
    logic [DATA_W-1:0]  changed_reg,  changed_next;
    logic [DATA_W-1:0]  toggles_reg,  toggles_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg,      out_next;

    logic [1:0]         new_ctrl;
    logic [PULSE_W-1:0] burst_pulses;
    logic [PULSE_W-1:0] pulses;
    logic [DATA_W-1:0]  rd;

    assign take      = item_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign new_ctrl  = item.write_data[1:0];

    // clamp of the burst length to 1..100000
    always_comb
    begin
        if (burst_reg == '0)
        begin
            burst_pulses = PULSE_W'(1);
        end
        else if (burst_reg > DATA_W'(MAX_BURST))
        begin
            burst_pulses = MAX_BURST;
        end
        else
        begin
            burst_pulses = burst_reg[PULSE_W-1:0];
        end
    end

    // register read mux
    always_comb
    begin
        case (item.offset)
            OFF_CONTROL:   rd = DATA_W'(control_reg);
            OFF_IRQ_NUM:   rd = DATA_W'(irq_num_reg);
            OFF_BURST:     rd = burst_reg;
            OFF_STATUS:    rd = DATA_W'({control_reg[CTRL_LEVEL_BIT], line_reg,
                                         control_reg[CTRL_ENABLE_BIT]});
            OFF_PERIOD:    rd = period_reg;
            OFF_PULSES_LO: rd = pulses_reg[31:0];
            OFF_PULSES_HI: rd = pulses_reg[63:32];
            OFF_FIRES:     rd = fires_reg;
            OFF_CHANGED:   rd = changed_reg;
            OFF_TOGGLES:   rd = toggles_reg;
            default:       rd = '0;
        endcase
    end

    always_comb
    begin
        control_next   = control_reg;
        burst_next     = burst_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        line_next      = line_reg;
        pulses_next    = pulses_reg;
        fires_next     = fires_reg;
        changed_next   = changed_reg;
        toggles_next   = toggles_reg;
        pulses         = '0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            case (item.action)
                ACT_WRITE:
                begin
                    case (item.offset)
                        OFF_CONTROL:
                        begin
                            if (new_ctrl != control_reg)
                            begin
                                changed_next = changed_reg + DATA_W'(1);
                                control_next = new_ctrl;
                            end
                            if (control_reg[CTRL_LEVEL_BIT] && !new_ctrl[CTRL_LEVEL_BIT])
                            begin
                                line_next = 1'b0;
                            end
                            if (control_reg[CTRL_ENABLE_BIT] != new_ctrl[CTRL_ENABLE_BIT])
                            begin
                                toggles_next = toggles_reg + DATA_W'(1);
                            end
                            if (new_ctrl[CTRL_ENABLE_BIT])
                            begin
                                if (!control_reg[CTRL_ENABLE_BIT])
                                begin
                                    countdown_next = reload_of(period_reg);
                                end
                            end
                            else
                            begin
                                line_next = 1'b0;
                            end
                        end
                        OFF_BURST:
                        begin
                            if (item.write_data != burst_reg)
                            begin
                                burst_next   = item.write_data;
                                changed_next = changed_reg + DATA_W'(1);
                            end
                        end
                        OFF_PERIOD:
                        begin
                            if (item.write_data != period_reg)
                            begin
                                period_next  = item.write_data;
                                changed_next = changed_reg + DATA_W'(1);
                                if (control_reg[CTRL_ENABLE_BIT])
                                begin
                                    countdown_next = reload_of(item.write_data);
                                end
                            end
                        end
                        OFF_ACK:
                        begin
                            if (item.write_data != '0)
                            begin
                                line_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ACT_TICK:
                begin
                    if (control_reg[CTRL_ENABLE_BIT])
                    begin
                        if (countdown_reg > DATA_W'(1))
                        begin
                            countdown_next = countdown_reg - DATA_W'(1);
                        end
                        else
                        begin
                            fires_next     = fires_reg + DATA_W'(1);
                            countdown_next = reload_of(period_reg);
                            if (control_reg[CTRL_LEVEL_BIT])
                            begin
                                if (!line_reg)
                                begin
                                    line_next   = 1'b1;
                                    pulses_next = pulses_reg + 64'd1;
                                end
                            end
                            else
                            begin
                                pulses      = burst_pulses;
                                pulses_next = pulses_reg + 64'(burst_pulses);
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
            out_valid_next       = 1'b1;
            out_next.read_data   = (item.action == ACT_READ) ? rd : '0;
            out_next.irq_level   = line_next;
            out_next.pulse_count = pulses;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= RST_CONTROL;
            irq_num_reg   <= RST_IRQ_NUM;
            burst_reg     <= RST_BURST;
            period_reg    <= RST_PERIOD;
            countdown_reg <= RST_PERIOD;
            line_reg      <= 1'b0;
            pulses_reg    <= '0;
            fires_reg     <= '0;
            changed_reg   <= '0;
            toggles_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            control_reg   <= control_next;
            burst_reg     <= burst_next;
            period_reg    <= period_next;
            countdown_reg <= countdown_next;
            line_reg      <= line_next;
            pulses_reg    <= pulses_next;
            fires_reg     <= fires_next;
            changed_reg   <= changed_next;
            toggles_reg   <= toggles_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                irq_num_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

FILE: hw/rtl/interrupt_storm_generator_core.sv
// ----------------------------------------------------------------------------
// interrupt_storm_generator_core
// The block takes one transaction per clock while its results are drained:
// a register read, a register write or a one-microsecond tick. Each
// transaction is captured in the input register and its result is then
// loaded into the result register, from which it leaves on m_tdata; while a
// result is stalled, the next transaction waits in the input register. The
// engine updates the register file, countdown and counters as each one is
// taken. The line-number register must be written by the user through
// cfg_wr_en/cfg_wr_data only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module interrupt_storm_generator_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [isg_pkg::IRQN_W-1:0]           cfg_wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // action[1:0], offset[6:2], write_data[38:7], unused[39]
    input  logic [isg_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // read_data[31:0], irq_level[32], pulse_count[49:33], zero[55:50]
    output logic [isg_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import isg_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    take;
    result_t res;

    isg_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    isg_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .take        (take),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res         (res)
    );

    assign m_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), res};

endmodule

FILE: hw/rtl/isg_checker.sv
// ----------------------------------------------------------------------------
// isg_checker
// port-level checks of the interrupt storm generator
// ----------------------------------------------------------------------------
`include "interrupt_storm_generator_core_macros.svh"

module isg_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [isg_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import isg_pkg::*;

    logic [PULSE_W-1:0] pulse_count;
    logic               irq_level;

    assign pulse_count = m_tdata[49:33];
    assign irq_level   = m_tdata[32];

    `ISG_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `ISG_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !m_tvalid, s_tready, "input stalled with empty output")
    `ISG_ASSERT_SAME(a_burst_clamp, clk, rst_n, m_tvalid, pulse_count <= MAX_BURST, "pulse count above burst limit")
    `ISG_ASSERT_SAME(a_edge_no_level, clk, rst_n, m_tvalid && (pulse_count != '0), !irq_level, "edge pulses with line asserted")

endmodule

bind interrupt_storm_generator_core isg_checker u_isg_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
